// File: design/vt44_pkg.sv
`timescale 1ns / 1ps
// Package for the 4x4 vertex transform core: widths, action codes and types.
// No dependencies; every design file imports it.
package vt44_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int WORD_W         = 32;
  localparam int MATRIX_ENTRIES = 16;
  localparam int IDX_W          = $clog2(MATRIX_ENTRIES);
  localparam int PROD_W         = 2 * WORD_W;
  localparam int RND_W          = PROD_W - FRAC_BITS;
  localparam int SUM_W          = RND_W + 2;
  localparam int COORDS         = 3;
  localparam int LANES          = 4;

  localparam int IN_BITS        = IDX_W + WORD_W * 4;
  localparam int IN_TDATA_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = WORD_W * LANES;

  localparam logic [WORD_W-1:0] WORD_ONE = WORD_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_XFORM = 1'b1
  } action_t;

  typedef logic [MATRIX_ENTRIES-1:0][WORD_W-1:0] matrix_t;

  // Register loads for the lane pipeline stages, driven by the top level.
  typedef struct packed {
    logic mul_en;
    logic rnd_en;
    logic sum_en;
    logic out_en;
  } lane_en_t;

  function automatic matrix_t identity_matrix();
    matrix_t m;
    m = '0;
    for (int i = 0; i < LANES; i++) begin
      m[i * 5] = WORD_ONE;
    end
    return m;
  endfunction

endpackage

// File: design/vt44_matrix.sv
`timescale 1ns / 1ps
// Matrix element store: sixteen column-major words, reset to identity.
// Depends on vt44_pkg.
module vt44_matrix
  import vt44_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [WORD_W-1:0] wr_data,
  output matrix_t           matrix_o
);

  matrix_t m_r;
  matrix_t m_nxt;

  always_comb begin
    m_nxt = m_r;
    if (wr_en) begin
      m_nxt[wr_idx] = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= identity_matrix();
    end else begin
      m_r <= m_nxt;
    end
  end

  assign matrix_o = m_r;

endmodule

// File: design/vt44_lane.sv
`timescale 1ns / 1ps
// One output component: three products, rounding, four-term sum, saturation.
// Depends on vt44_pkg; stage loads come from the top level.
module vt44_lane
  import vt44_pkg::*;
(
  input  logic                     clk,
  input  lane_en_t                 en,
  input  logic signed [WORD_W-1:0] coord_i [COORDS],
  input  logic signed [WORD_W-1:0] coef_i  [COORDS],
  input  logic signed [WORD_W-1:0] trans_i,
  output logic        [WORD_W-1:0] result_o
);

  logic signed [PROD_W-1:0] prod_r  [COORDS];
  logic signed [PROD_W-1:0] half_sum [COORDS];
  logic signed [RND_W-1:0]  rnd_r   [COORDS];
  logic signed [WORD_W-1:0] trans_b_r;
  logic signed [WORD_W-1:0] trans_c_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic        [SUM_W-WORD_W:0] sum_hi;
  logic        [WORD_W-1:0] res_r;
  logic        [WORD_W-1:0] res_nxt;

  // Round half up: add half an LSB, then the arithmetic shift is a part-select.
  always_comb begin
    for (int k = 0; k < COORDS; k++) begin
      half_sum[k] = prod_r[k] + PROD_HALF;
    end
  end

  always_comb begin
    sum_nxt = SUM_W'(rnd_r[0]) + SUM_W'(rnd_r[1]) + SUM_W'(rnd_r[2]) + SUM_W'(trans_c_r);
  end

  // The sum fits in 32 bits when all bits from the sign of the word up agree.
  always_comb begin
    sum_hi = sum_r[SUM_W-1:WORD_W-1];
    if ((&sum_hi) || !(|sum_hi)) begin
      res_nxt = sum_r[WORD_W-1:0];
    end else if (sum_r[SUM_W-1]) begin
      res_nxt = WORD_MIN;
    end else begin
      res_nxt = WORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      for (int k = 0; k < COORDS; k++) begin
        prod_r[k] <= coord_i[k] * coef_i[k];
      end
      trans_b_r <= trans_i;
    end
    if (en.rnd_en) begin
      for (int k = 0; k < COORDS; k++) begin
        rnd_r[k] <= half_sum[k][PROD_W-1:FRAC_BITS];
      end
      trans_c_r <= trans_b_r;
    end
    if (en.sum_en) begin
      sum_r <= sum_nxt;
    end
    if (en.out_en) begin
      res_r <= res_nxt;
    end
  end

  assign result_o = res_r;

endmodule

// File: design/vertex_transform_4x4_core.sv
`timescale 1ns / 1ps
// Top level of the 4x4 vertex transform core: handshake, stage valids,
// matrix store and four output lanes. Depends on vt44_pkg, vt44_matrix, vt44_lane.
//
//  channel | dir | tuser        | tdata (lowest bit first)
//  --------+-----+--------------+---------------------------------------------
//  in_     | in  | action       | elem_index, elem_value, vx, vy, vz, 4 pad bits
//  out_    | out | -            | tx, ty, tz, tw
//
// A transform word runs through five register stages: input capture, the
// twelve 32x32 multiplies, rounding, the four-term sum, and saturation into
// the output register. One word can be accepted every cycle while out_tready
// is high; the multiplier stage sets the cycle time. A load word writes the
// matrix at the edge it is accepted and produces no output word.
// Reset (rst_n low, synchronous) empties the pipeline and sets the matrix to
// identity. When out_tready is low, stages fill up from the output backward;
// in_tready drops only once the input stage is full and cannot move, so no
// word is lost or repeated. Because a load is only taken while the input
// stage is empty or moving, a transform always uses the matrix as it was when
// that transform was accepted.
module vertex_transform_4x4_core
  import vt44_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tuser,   // action
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // elem_index, elem_value, vx, vy, vz
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // tx, ty, tz, tw
);

  localparam int VAL_LO = IDX_W;
  localparam int VX_LO  = VAL_LO + WORD_W;
  localparam int VY_LO  = VX_LO + WORD_W;
  localparam int VZ_LO  = VY_LO + WORD_W;

  action_t  in_action;
  logic     in_acc;
  logic     load_acc;
  logic     xform_acc;

  // Valid bits of the five stages: input, multiply, round, sum, output.
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_o_r;
  logic v_a_nxt, v_b_nxt, v_c_nxt, v_d_nxt, v_o_nxt;
  // A stage can take a new word when it is empty or its word moves on.
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;

  logic signed [WORD_W-1:0] vert_r [COORDS];
  matrix_t  matrix;
  lane_en_t lane_en;
  logic [WORD_W-1:0] lane_res [LANES];

  assign in_action = action_t'(in_tuser);
  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_action == ACT_LOAD);
  assign xform_acc = in_acc && (in_action == ACT_XFORM);

  always_comb begin
    rdy_o = !v_o_r || out_tready;
    rdy_d = !v_d_r || rdy_o;
    rdy_c = !v_c_r || rdy_d;
    rdy_b = !v_b_r || rdy_c;
    rdy_a = !v_a_r || rdy_b;
  end

  assign in_tready = rdy_a;

  always_comb begin
    v_a_nxt = rdy_a ? (in_tvalid && (in_action == ACT_XFORM)) : v_a_r;
    v_b_nxt = rdy_b ? v_a_r : v_b_r;
    v_c_nxt = rdy_c ? v_b_r : v_c_r;
    v_d_nxt = rdy_d ? v_c_r : v_d_r;
    v_o_nxt = rdy_o ? v_d_r : v_o_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_o_r <= 1'b0;
    end else begin
      v_a_r <= v_a_nxt;
      v_b_r <= v_b_nxt;
      v_c_r <= v_c_nxt;
      v_d_r <= v_d_nxt;
      v_o_r <= v_o_nxt;
    end
  end

  // Vertex capture; the coordinates are only meaningful for transform words.
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      vert_r[0] <= in_tdata[VX_LO +: WORD_W];
      vert_r[1] <= in_tdata[VY_LO +: WORD_W];
      vert_r[2] <= in_tdata[VZ_LO +: WORD_W];
    end
  end

  vt44_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (load_acc),
    .wr_idx   (in_tdata[IDX_W-1:0]),
    .wr_data  (in_tdata[VAL_LO +: WORD_W]),
    .matrix_o (matrix)
  );

  // Each stage register loads whenever its stage is ready; payload of an
  // empty slot is don't-care since the valid bit travels beside it.
  always_comb begin
    lane_en.mul_en = rdy_b;
    lane_en.rnd_en = rdy_c;
    lane_en.sum_en = rdy_d;
    lane_en.out_en = rdy_o;
  end

  // Lane j takes column entries j, 4+j, 8+j and the translation 12+j.
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic signed [WORD_W-1:0] coef [COORDS];

    for (genvar k = 0; k < COORDS; k++) begin : g_coef
      assign coef[k] = matrix[k * LANES + j];
    end

    vt44_lane u_lane (
      .clk      (clk),
      .en       (lane_en),
      .coord_i  (vert_r),
      .coef_i   (coef),
      .trans_i  (matrix[COORDS * LANES + j]),
      .result_o (lane_res[j])
    );

    assign out_tdata[j * WORD_W +: WORD_W] = lane_res[j];
  end

  assign out_tvalid = v_o_r;

  // An empty output register means nothing upstream may block.
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_o_r |-> in_tready)
    else $error("input stalled while the output register is empty");

  // A matrix write must never overtake a transform still waiting to multiply.
  a_load_order: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |-> (!v_a_r || rdy_b))
    else $error("matrix written while a held transform has not multiplied");

  a_xform_enters: assert property (@(posedge clk) disable iff (!rst_n)
    xform_acc |=> v_a_r)
    else $error("accepted transform word did not enter the input stage");

  a_sum_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v_d_r && rdy_o) |=> v_o_r)
    else $error("sum stage word lost on its way to the output register");

endmodule
